@@ rtl/wcvl_pkg.sv @@
package wcvl_pkg;

  // Field and storage widths
  localparam int CNT_W        = 3;
  localparam int LIM_W        = 8;
  localparam int BIN_W        = 9;
  localparam int NUM_BINS     = 6;
  localparam int BIN_IDX_W    = $clog2(NUM_BINS);
  localparam int CFG_IDX_W    = 1;
  localparam int OUT_LIGHTS_W = 5;

  // Number of lights driven; light numbers run from 1 to NUM_LIGHTS
  localparam int NUM_LIGHTS   = 5;
  localparam int LIGHT_NUM_W  = 4;
  localparam int SHOWN_LIGHTS = (NUM_LIGHTS < OUT_LIGHTS_W) ? NUM_LIGHTS : OUT_LIGHTS_W;

  localparam logic [CNT_W-1:0] MAX_COUNT = 3'd5;
  localparam logic [BIN_W-1:0] BIN_MAX   = 9'd511;
  localparam logic [LIM_W-1:0] CTR_MAX   = 8'd255;
  localparam logic [LIM_W-1:0] LIM_RESET = 8'd10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DONE
  } wcvl_state_t;

  typedef struct packed {
    logic inc;
    logic clr;
  } hist_ctrl_t;

  typedef struct packed {
    logic step;
    logic first;
  } scan_ctrl_t;

  // One-hot mask of the light selected by a mode value; zero if none
  function automatic logic [NUM_LIGHTS-1:0] light_mask(input logic [CNT_W-1:0] mode);
    logic [NUM_LIGHTS-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_LIGHTS; i++) begin
      m[i] = (LIGHT_NUM_W'(mode) == LIGHT_NUM_W'(i + 1));
    end
    return m;
  endfunction

endpackage

@@ rtl/wcvl_hist.sv @@
module wcvl_hist
  import wcvl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  hist_ctrl_t           ctrl,
  input  logic [BIN_IDX_W-1:0] addr,
  output logic [BIN_W-1:0]     rd_data
);

  logic [BIN_W-1:0] bins_r [NUM_BINS];
  logic             addr_ok;

  assign addr_ok = (addr < BIN_IDX_W'(NUM_BINS));

  // Read the addressed bin
  assign rd_data = addr_ok ? bins_r[addr] : '0;

  // Clear all bins, or bump the addressed bin with saturation
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_r[i] <= '0;
      end
    end else if (ctrl.inc && addr_ok && (rd_data < BIN_MAX)) begin
      bins_r[addr] <= rd_data + BIN_W'(1);
    end
  end

endmodule

@@ rtl/wcvl_mode_scan.sv @@
module wcvl_mode_scan
  import wcvl_pkg::*;
(
  input  logic                 clk,
  input  scan_ctrl_t           ctrl,
  input  logic [BIN_IDX_W-1:0] bin_idx,
  input  logic [BIN_W-1:0]     bin_count,
  output logic [BIN_IDX_W-1:0] best
);

  logic [BIN_IDX_W-1:0] best_r,   best_nxt;
  logic [BIN_W-1:0]     best_n_r, best_n_nxt;
  logic                 take;

  // Shared compare: a strictly larger count wins, so ties keep the smaller value
  assign take = ctrl.first || (bin_count > best_n_r);

  always_comb begin
    best_nxt   = best_r;
    best_n_nxt = best_n_r;
    if (ctrl.step && take) begin
      best_nxt   = bin_idx;
      best_n_nxt = bin_count;
    end
  end

  always_ff @(posedge clk) begin
    best_r   <= best_nxt;
    best_n_r <= best_n_nxt;
  end

  assign best = best_r;

endmodule

@@ rtl/windowed_count_vote_light_control.sv @@
// Without a vote an item passes through the update and done states to the
// output register; on a vote, a six-step scan of the histogram bins comes between.
// A new item is taken only once the done state has loaded the last result into a free
// output register; on a voting frame the shared comparator's bin scan holds it off longer.
// Reset (rst_n low, synchronous): counters, histogram, mode and lights clear,
// both limits return to 10, no result is pending.
module windowed_count_vote_light_control
  import wcvl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [LIM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CNT_W-1:0]        in_finger_count,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CNT_W-1:0]        out_shown_count,
  output logic                    out_collecting,
  output logic                    out_window_done,
  output logic                    out_light_changed,
  output logic [CNT_W-1:0]        out_light_index,
  output logic                    out_light_on,
  output logic [OUT_LIGHTS_W-1:0] out_light_states
);

  wcvl_state_t state_r, state_nxt;

  logic [LIM_W-1:0]      warm_lim_r, win_lim_r;
  logic [LIM_W-1:0]      warm_r, warm_nxt;
  logic [LIM_W-1:0]      win_r, win_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  collect_r, collect_nxt;
  logic                  vote_r, vote_nxt;
  logic [BIN_IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]      mode_r, mode_nxt;
  logic [NUM_LIGHTS-1:0] lights_r, lights_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]        shown_r, shown_nxt;
  logic                    ocoll_r, ocoll_nxt;
  logic                    odone_r, odone_nxt;
  logic                    ochg_r, ochg_nxt;
  logic [CNT_W-1:0]        oidx_r, oidx_nxt;
  logic                    oon_r, oon_nxt;
  logic [OUT_LIGHTS_W-1:0] ostates_r, ostates_nxt;

  hist_ctrl_t           hist_ctrl;
  scan_ctrl_t           scan_ctrl;
  logic [BIN_IDX_W-1:0] hist_addr;
  logic [BIN_W-1:0]     hist_data;
  logic [BIN_IDX_W-1:0] best;
  logic [CNT_W-1:0]     new_mode;
  logic [NUM_LIGHTS-1:0] mask;
  logic                 accept;
  logic                 out_space;

  wcvl_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (hist_ctrl),
    .addr    (hist_addr),
    .rd_data (hist_data)
  );

  wcvl_mode_scan u_scan (
    .clk       (clk),
    .ctrl      (scan_ctrl),
    .bin_idx   (scan_idx_r),
    .bin_count (hist_data),
    .best      (best)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_space = !out_valid_r || !out_stall;
  assign new_mode  = CNT_W'(best);

  // Sequencer: next state, counters, histogram control and result
  always_comb begin
    state_nxt     = state_r;
    warm_nxt      = warm_r;
    win_nxt       = win_r;
    cnt_nxt       = cnt_r;
    collect_nxt   = collect_r;
    vote_nxt      = vote_r;
    scan_idx_nxt  = scan_idx_r;
    mode_nxt      = mode_r;
    lights_nxt    = lights_r;
    out_valid_nxt = out_valid_r && out_stall;
    shown_nxt     = shown_r;
    ocoll_nxt     = ocoll_r;
    odone_nxt     = odone_r;
    ochg_nxt      = ochg_r;
    oidx_nxt      = oidx_r;
    oon_nxt       = oon_r;
    ostates_nxt   = ostates_r;
    hist_ctrl     = '0;
    scan_ctrl     = '0;
    hist_addr     = BIN_IDX_W'(cnt_r);
    mask          = '0;

    case (state_r)
      ST_IDLE: begin
        // Take the count, saturated to the top bin
        if (accept) begin
          cnt_nxt   = (in_finger_count > MAX_COUNT) ? MAX_COUNT : in_finger_count;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (warm_r > warm_lim_r) begin
          collect_nxt   = 1'b1;
          hist_ctrl.inc = 1'b1;
          if (win_r > win_lim_r) begin
            vote_nxt     = 1'b1;
            warm_nxt     = '0;
            win_nxt      = '0;
            scan_idx_nxt = '0;
            state_nxt    = ST_SCAN;
          end else begin
            vote_nxt  = 1'b0;
            if (win_r != CTR_MAX) win_nxt = win_r + LIM_W'(1);
            state_nxt = ST_DONE;
          end
        end else begin
          collect_nxt = 1'b0;
          vote_nxt    = 1'b0;
          if (warm_r != CTR_MAX) warm_nxt = warm_r + LIM_W'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        // One bin per cycle through the shared comparator
        hist_addr       = scan_idx_r;
        scan_ctrl.step  = 1'b1;
        scan_ctrl.first = (scan_idx_r == '0);
        if (scan_idx_r == BIN_IDX_W'(NUM_BINS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          scan_idx_nxt = scan_idx_r + BIN_IDX_W'(1);
        end
      end
      ST_DONE: begin
        // Load the result once the output register is free
        if (out_space) begin
          out_valid_nxt = 1'b1;
          ocoll_nxt     = collect_r;
          odone_nxt     = vote_r;
          ochg_nxt      = 1'b0;
          oidx_nxt      = '0;
          oon_nxt       = 1'b0;
          shown_nxt     = mode_r;
          if (vote_r) begin
            hist_ctrl.clr = 1'b1;
            mode_nxt      = new_mode;
            shown_nxt     = new_mode;
            if (mode_r != new_mode) begin
              if (new_mode != '0) begin
                mask = light_mask(new_mode);
                if (mask != '0) begin
                  lights_nxt = lights_r | mask;
                  ochg_nxt   = 1'b1;
                  oidx_nxt   = new_mode;
                  oon_nxt    = 1'b1;
                end
              end else begin
                mask = light_mask(mode_r);
                if (mask != '0) begin
                  lights_nxt = lights_r & ~mask;
                  ochg_nxt   = 1'b1;
                  oidx_nxt   = mode_r;
                  oon_nxt    = 1'b0;
                end
              end
            end
          end
          ostates_nxt = '0;
          for (int i = 0; i < SHOWN_LIGHTS; i++) begin
            ostates_nxt[i] = lights_nxt[i];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and vote state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r      <= '0;
      win_r       <= '0;
      mode_r      <= '0;
      lights_r    <= '0;
      out_valid_r <= 1'b0;
      collect_r   <= 1'b0;
      vote_r      <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      warm_r      <= warm_nxt;
      win_r       <= win_nxt;
      mode_r      <= mode_nxt;
      lights_r    <= lights_nxt;
      out_valid_r <= out_valid_nxt;
      collect_r   <= collect_nxt;
      vote_r      <= vote_nxt;
      scan_idx_r  <= scan_idx_nxt;
    end
  end

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_lim_r <= LIM_RESET;
      win_lim_r  <= LIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WARMUP_LIMIT: warm_lim_r <= cfg_data;
        REG_WINDOW_LIMIT: win_lim_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    shown_r   <= shown_nxt;
    ocoll_r   <= ocoll_nxt;
    odone_r   <= odone_nxt;
    ochg_r    <= ochg_nxt;
    oidx_r    <= oidx_nxt;
    oon_r     <= oon_nxt;
    ostates_r <= ostates_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_shown_count   = shown_r;
  assign out_collecting    = ocoll_r;
  assign out_window_done   = odone_r;
  assign out_light_changed = ochg_r;
  assign out_light_index   = oidx_r;
  assign out_light_on      = oon_r;
  assign out_light_states  = ostates_r;

  // A vote only ever happens on a collected frame
  a_done_collects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_done |-> out_collecting)
    else $error("vote reported on a frame that was not collected");

  // Switch fields stay zero without a switch, and a switch needs a vote
  a_no_switch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_light_changed |-> (out_light_index == '0) && !out_light_on)
    else $error("light fields set without a switch");

  a_switch_needs_vote: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_light_changed |-> out_window_done && (out_light_index != '0))
    else $error("light switched outside a vote");

  // An accepted item always starts with the update step
  a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_UPDATE)
    else $error("accepted item did not enter update");

  // The scan never runs past the last bin
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> scan_idx_r < BIN_IDX_W'(NUM_BINS))
    else $error("scan index out of range");

endmodule
